// ===== rtl/ilff_pkg.sv =====
// Package for the implicit-list first-fit allocator: payload types, status codes,
// boundary-tag constants and the control word of the shared adder.
// No dependencies.
package ilff_pkg;

    localparam int WORD_W      = 32;
    localparam int REQ_W       = 16;
    localparam int OFFSET_W    = 16;
    localparam int WORD_BYTES  = 4;
    localparam int DWORD_BYTES = 8;
    localparam int MIN_BLOCK   = 2 * DWORD_BYTES;
    localparam int ALLOC_BIT   = 1;
    localparam int OFS_W       = 5;

    typedef enum logic [1:0] {
        ST_GRANTED   = 2'd0,
        ST_ZERO      = 2'd1,
        ST_EXHAUSTED = 2'd2
    } status_t;

    typedef struct packed {
        logic [REQ_W-1:0] request_bytes;
    } req_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] block_offset;
        status_t             status;
    } rsp_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // Small signed offsets folded into the adder result.
    localparam logic signed [OFS_W-1:0] OFS_NONE  = 5'sd0;
    localparam logic signed [OFS_W-1:0] OFS_HDR   = -5'sd4;
    localparam logic signed [OFS_W-1:0] OFS_FTR   = -5'sd8;
    localparam logic signed [OFS_W-1:0] OFS_ROUND = 5'sd15;

    typedef struct packed {
        alu_op_t                  op;
        logic signed [OFS_W-1:0]  ofs;
    } alu_ctl_t;

endpackage

// ===== rtl/ilff_stream_if.sv =====
// Valid/ready stream interface used for the request and response channels.
// Depends on nothing; the payload type is given at instantiation.
interface ilff_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/implicit_list_first_fit_allocator.sv =====
// Top level of the implicit-list first-fit allocator: sequencer, heap memory
// and registers. Depends on ilff_pkg, ilff_stream_if and ilff_alu.
//
// Usage: a beat on req carries request_bytes. Exactly one beat comes back on
// rsp for it, carrying block_offset (payload byte offset in the heap) and
// status (granted, zero-size request, heap exhausted). req is ready only
// while the sequencer is idle; one request is handled at a time, so the next
// request is taken at the earliest in the cycle after the response is loaded.
// The first-fit walk reads one block header per heap memory access, and a
// granted block may be split. A walk that finds no fit grows the heap, and
// the new space merges with a trailing free block; a refusal for lack of
// space comes after the walk. The very first request also lays down the
// frame and the first chunk.
// Results go into an output register, so a new request is accepted while the
// previous response still waits; if the receiver stalls, the sequencer holds
// its finished result until the output register frees up.
// Reset clears the state, the break, the layout flag and the output valid;
// heap words are undefined until written and need no clearing pass.
module implicit_list_first_fit_allocator #(
    parameter int HEAP_BYTES  = 65536,
    parameter int CHUNK_BYTES = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    ilff_stream_if.sink   req,
    ilff_stream_if.source rsp
);

    localparam int HEAP_WORDS = HEAP_BYTES / ilff_pkg::WORD_BYTES;
    localparam int WIW        = $clog2(HEAP_WORDS);
    localparam int AW         = $clog2(HEAP_BYTES + 1);
    localparam int DW         = ((AW > 17) ? AW : 17) + 2;
    // The first chunk and small growths use the chunk rounded to an even word count.
    localparam int CHUNK_EXT  = ((CHUNK_BYTES / ilff_pkg::WORD_BYTES + 1) / 2) * 8;

    localparam logic [DW-1:0] C_ZERO     = '0;
    localparam logic [DW-1:0] C_WORD     = DW'(ilff_pkg::WORD_BYTES);
    localparam logic [DW-1:0] C_DWORD    = DW'(ilff_pkg::DWORD_BYTES);
    localparam logic [DW-1:0] C_EPI      = DW'(3 * ilff_pkg::WORD_BYTES);
    localparam logic [DW-1:0] C_FRAME    = DW'(4 * ilff_pkg::WORD_BYTES);
    localparam logic [DW-1:0] C_MIN      = DW'(ilff_pkg::MIN_BLOCK);
    localparam logic [DW-1:0] HEAP_LIM   = DW'(HEAP_BYTES);
    localparam logic [DW-1:0] HEAP_WLIM  = DW'(HEAP_WORDS);
    localparam logic [DW-1:0] CHUNK_LIM  = DW'(CHUNK_BYTES);
    localparam logic [DW-1:0] CHUNK_SZ   = DW'(CHUNK_EXT);
    localparam logic [ilff_pkg::REQ_W-1:0] SMALL_REQ =
        ilff_pkg::REQ_W'(ilff_pkg::DWORD_BYTES);

    typedef enum logic [4:0] {
        S_IDLE, S_LAY0, S_LAY1, S_LAY2, S_LAY3, S_SIZE, S_WALK_RD, S_WALK_EV,
        S_EXT, S_GROW, S_X0, S_X1, S_X2, S_M0, S_M1, S_M2, S_M3, S_M4,
        S_XDONE, S_PUT, S_P0, S_P1, S_P2, S_P3, S_RESP
    } state_t;

    // Packs a size into a heap word with the allocated flag in bit 0.
    function automatic logic [ilff_pkg::WORD_W-1:0] to_word(input logic [DW-1:0] v,
                                                           input logic alloc);
        return {{(ilff_pkg::WORD_W-DW){1'b0}}, v} | {{(ilff_pkg::WORD_W-1){1'b0}}, alloc};
    endfunction

    state_t state_reg, state_next;
    logic   hready_reg, hready_next;
    logic [DW-1:0] brk_reg, brk_next;
    logic   outv_reg, outv_next;
    ilff_pkg::rsp_t outd_reg, outd_next;

    logic [ilff_pkg::REQ_W-1:0] n_reg, n_next;
    logic [DW-1:0] bp_reg, bp_next;
    logic [DW-1:0] size_reg, size_next;
    logic [DW-1:0] asize_reg, asize_next;
    logic [DW-1:0] hsize_reg, hsize_next;
    logic [DW-1:0] tmp_reg, tmp_next;
    logic          lay_reg, lay_next;
    logic          split_reg, split_next;
    ilff_pkg::rsp_t res_reg, res_next;

    logic [DW-1:0]      alu_a, alu_b, alu_y;
    ilff_pkg::alu_ctl_t alu_ctl;

    logic                        mem_we, mem_re, mem_ok;
    logic [DW-1:0]               mem_addr;
    logic [WIW-1:0]              mem_idx;
    logic [ilff_pkg::WORD_W-1:0] mem_wdata;
    logic [ilff_pkg::WORD_W-1:0] rdata_reg;
    logic [ilff_pkg::WORD_W-1:0] heap_mem [HEAP_WORDS];

    logic [DW-1:0] rsize;
    logic          split_now;

    ilff_alu #(.W(DW)) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .ctl (alu_ctl),
        .y   (alu_y)
    );

    // Size field of the word just read, low three bits masked off.
    assign rsize = {{(DW-AW){1'b0}}, rdata_reg[AW-1:3], 3'b000};

    assign mem_ok  = (mem_addr >> 2) < HEAP_WLIM;
    assign mem_idx = mem_addr[WIW+1:2];

    // Heap word memory: one access a cycle, registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we && mem_ok)
        begin
            heap_mem[mem_idx] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem_ok ? heap_mem[mem_idx] : '0;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = outv_reg;
    assign rsp.data  = outd_reg;

    always_comb
    begin
        state_next  = state_reg;
        hready_next = hready_reg;
        brk_next    = brk_reg;
        n_next      = n_reg;
        bp_next     = bp_reg;
        size_next   = size_reg;
        asize_next  = asize_reg;
        hsize_next  = hsize_reg;
        tmp_next    = tmp_reg;
        lay_next    = lay_reg;
        split_next  = split_reg;
        res_next    = res_reg;
        outd_next   = outd_reg;
        outv_next   = outv_reg && !rsp.ready;

        alu_a     = bp_reg;
        alu_b     = '0;
        alu_ctl   = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_NONE};
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = C_ZERO;
        mem_wdata = '0;
        split_now = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    n_next     = req.data.request_bytes;
                    state_next = hready_reg ? S_SIZE : S_LAY0;
                end
            end
            // Frame: padding word, prologue header and footer, epilogue header.
            S_LAY0:
            begin
                mem_we     = 1'b1;
                mem_addr   = C_ZERO;
                mem_wdata  = '0;
                state_next = S_LAY1;
            end
            S_LAY1:
            begin
                mem_we     = 1'b1;
                mem_addr   = C_WORD;
                mem_wdata  = to_word(C_DWORD, 1'b1);
                state_next = S_LAY2;
            end
            S_LAY2:
            begin
                mem_we     = 1'b1;
                mem_addr   = C_DWORD;
                mem_wdata  = to_word(C_DWORD, 1'b1);
                state_next = S_LAY3;
            end
            S_LAY3:
            begin
                mem_we      = 1'b1;
                mem_addr    = C_EPI;
                mem_wdata   = to_word(C_ZERO, 1'b1);
                brk_next    = C_FRAME;
                hready_next = 1'b1;
                size_next   = CHUNK_SZ;
                lay_next    = 1'b1;
                state_next  = S_GROW;
            end
            S_SIZE:
            begin
                alu_a   = {{(DW-ilff_pkg::REQ_W){1'b0}}, n_reg};
                alu_ctl = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_ROUND};
                if (n_reg == '0)
                begin
                    res_next   = '{block_offset: '0, status: ilff_pkg::ST_ZERO};
                    state_next = S_RESP;
                end
                else
                begin
                    asize_next = (n_reg <= SMALL_REQ) ? C_MIN : {alu_y[DW-1:3], 3'b000};
                    bp_next    = C_DWORD;
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                alu_a   = bp_reg;
                alu_ctl = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_HDR};
                if (bp_reg < brk_reg)
                begin
                    mem_re     = 1'b1;
                    mem_addr   = alu_y;
                    state_next = S_WALK_EV;
                end
                else
                begin
                    state_next = S_EXT;
                end
            end
            S_WALK_EV:
            begin
                alu_a = bp_reg;
                alu_b = rsize;
                if (rsize == C_ZERO)
                begin
                    state_next = S_EXT;
                end
                else if (!rdata_reg[0] && (asize_reg <= rsize))
                begin
                    size_next  = rsize;
                    state_next = S_PUT;
                end
                else
                begin
                    bp_next    = alu_y;
                    state_next = S_WALK_RD;
                end
            end
            S_EXT:
            begin
                size_next  = (asize_reg > CHUNK_LIM) ? asize_reg : CHUNK_SZ;
                lay_next   = 1'b0;
                state_next = S_GROW;
            end
            S_GROW:
            begin
                alu_a = brk_reg;
                alu_b = size_reg;
                if (alu_y > HEAP_LIM)
                begin
                    // A first chunk that does not fit is dropped silently.
                    if (lay_reg)
                    begin
                        state_next = S_SIZE;
                    end
                    else
                    begin
                        res_next   = '{block_offset: '0, status: ilff_pkg::ST_EXHAUSTED};
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    bp_next    = brk_reg;
                    brk_next   = alu_y;
                    state_next = S_X0;
                end
            end
            S_X0:
            begin
                alu_ctl    = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_HDR};
                mem_we     = 1'b1;
                mem_addr   = alu_y;
                mem_wdata  = to_word(size_reg, 1'b0);
                state_next = S_X1;
            end
            S_X1:
            begin
                alu_b      = size_reg;
                alu_ctl    = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_FTR};
                mem_we     = 1'b1;
                mem_addr   = alu_y;
                mem_wdata  = to_word(size_reg, 1'b0);
                state_next = S_X2;
            end
            S_X2:
            begin
                alu_a      = brk_reg;
                alu_ctl    = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_HDR};
                mem_we     = 1'b1;
                mem_addr   = alu_y;
                mem_wdata  = to_word(C_ZERO, 1'b1);
                state_next = S_M0;
            end
            // The block after the new space is the epilogue, always allocated,
            // so only the previous block can merge. Its footer carries the flag.
            S_M0:
            begin
                alu_ctl    = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_FTR};
                mem_re     = 1'b1;
                mem_addr   = alu_y;
                state_next = S_M1;
            end
            S_M1:
            begin
                alu_a = size_reg;
                alu_b = rsize;
                if (rdata_reg[0])
                begin
                    state_next = S_XDONE;
                end
                else
                begin
                    tmp_next   = rsize;
                    size_next  = alu_y;
                    state_next = S_M2;
                end
            end
            S_M2:
            begin
                alu_b      = tmp_reg;
                alu_ctl    = '{op: ilff_pkg::ALU_SUB, ofs: ilff_pkg::OFS_NONE};
                bp_next    = alu_y;
                state_next = S_M3;
            end
            S_M3:
            begin
                alu_ctl    = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_HDR};
                mem_we     = 1'b1;
                mem_addr   = alu_y;
                mem_wdata  = to_word(size_reg, 1'b0);
                state_next = S_M4;
            end
            S_M4:
            begin
                alu_b      = size_reg;
                alu_ctl    = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_FTR};
                mem_we     = 1'b1;
                mem_addr   = alu_y;
                mem_wdata  = to_word(size_reg, 1'b0);
                state_next = S_XDONE;
            end
            S_XDONE:
            begin
                state_next = lay_reg ? S_SIZE : S_PUT;
            end
            S_PUT:
            begin
                alu_a      = size_reg;
                alu_b      = asize_reg;
                alu_ctl    = '{op: ilff_pkg::ALU_SUB, ofs: ilff_pkg::OFS_NONE};
                split_now  = (alu_y >= C_MIN);
                tmp_next   = alu_y;
                split_next = split_now;
                hsize_next = split_now ? asize_reg : size_reg;
                state_next = S_P0;
            end
            S_P0:
            begin
                alu_ctl    = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_HDR};
                mem_we     = 1'b1;
                mem_addr   = alu_y;
                mem_wdata  = to_word(hsize_reg, 1'b1);
                state_next = S_P1;
            end
            S_P1:
            begin
                alu_b     = hsize_reg;
                alu_ctl   = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_FTR};
                mem_we    = 1'b1;
                mem_addr  = alu_y;
                mem_wdata = to_word(hsize_reg, 1'b1);
                if (split_reg)
                begin
                    state_next = S_P2;
                end
                else
                begin
                    res_next   = '{block_offset: bp_reg[ilff_pkg::OFFSET_W-1:0],
                                   status: ilff_pkg::ST_GRANTED};
                    state_next = S_RESP;
                end
            end
            S_P2:
            begin
                alu_b      = hsize_reg;
                alu_ctl    = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_HDR};
                mem_we     = 1'b1;
                mem_addr   = alu_y;
                mem_wdata  = to_word(tmp_reg, 1'b0);
                state_next = S_P3;
            end
            S_P3:
            begin
                alu_b      = size_reg;
                alu_ctl    = '{op: ilff_pkg::ALU_ADD, ofs: ilff_pkg::OFS_FTR};
                mem_we     = 1'b1;
                mem_addr   = alu_y;
                mem_wdata  = to_word(tmp_reg, 1'b0);
                res_next   = '{block_offset: bp_reg[ilff_pkg::OFFSET_W-1:0],
                               status: ilff_pkg::ST_GRANTED};
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!outv_reg || rsp.ready)
                begin
                    outv_next  = 1'b1;
                    outd_next  = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, break and output valid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            hready_reg <= 1'b0;
            brk_reg    <= '0;
            outv_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hready_reg <= hready_next;
            brk_reg    <= brk_next;
            outv_reg   <= outv_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        outd_reg  <= outd_next;
        n_reg     <= n_next;
        bp_reg    <= bp_next;
        size_reg  <= size_next;
        asize_reg <= asize_next;
        hsize_reg <= hsize_next;
        tmp_reg   <= tmp_next;
        lay_reg   <= lay_next;
        split_reg <= split_next;
        res_reg   <= res_next;
    end

    // The break never passes the end of the heap.
    assert property (@(posedge clk) disable iff (!rst_n) brk_reg <= HEAP_LIM)
        else $error("heap break beyond heap end");

    // All blocks are double-word multiples, so the break stays aligned.
    assert property (@(posedge clk) disable iff (!rst_n) brk_reg[2:0] == 3'b000)
        else $error("heap break misaligned");

    // A well-formed heap never writes outside the memory.
    assert property (@(posedge clk) disable iff (!rst_n) mem_we |-> mem_ok)
        else $error("heap write out of range");

    // Laying out the frame sets the break to the frame size.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(hready_reg) |-> brk_reg == C_FRAME)
        else $error("frame laid out with wrong break");

    // A response that is not a grant carries a zero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.data.status != ilff_pkg::ST_GRANTED)) |-> (rsp.data.block_offset == '0))
        else $error("refused response with nonzero offset");

endmodule

// ===== rtl/ilff_alu.sv =====
// Shared adder/subtractor of the allocator datapath with a small signed offset.
// Depends on ilff_pkg for the control word.
module ilff_alu #(
    parameter int W = 19
) (
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    input  ilff_pkg::alu_ctl_t ctl,
    output logic [W-1:0]      y
);

    logic [W-1:0] base;
    logic [W-1:0] ofs_ext;

    assign ofs_ext = {{(W-ilff_pkg::OFS_W){ctl.ofs[ilff_pkg::OFS_W-1]}}, ctl.ofs};
    assign base    = (ctl.op == ilff_pkg::ALU_SUB) ? (a - b) : (a + b);
    assign y       = base + ofs_ext;

endmodule
